@@ src/collision_narrowphase_test_unit_macros.svh @@
// assertion macros for the collision narrow-phase test unit
`ifndef COLLISION_NARROWPHASE_TEST_UNIT_MACROS_SVH
`define COLLISION_NARROWPHASE_TEST_UNIT_MACROS_SVH

// property checked only outside reset
`define CNP_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CNP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/cnp_pkg.sv @@
// shared types, constants and helpers of the collision narrow-phase test unit
`default_nettype none
package cnp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FIELD_W     = 48;
  localparam int RAD_W       = 16;
  localparam int AXES        = 3;

  localparam int PAD_W  = AXES * COORD_WIDTH + FIELD_W;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int D2_W   = SQ_W + 2;
  localparam int RS_W   = RAD_W + 1;
  localparam int RSQ_W  = 2 * RS_W;
  localparam int CMP_W  = (D2_W > RSQ_W) ? D2_W : RSQ_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic [SQ_W-1:0]               sq_t;

  typedef enum logic [1:0] {
    MODE_SS = 2'd0,
    MODE_SB = 2'd1,
    MODE_BB = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  bb_hit;
    coord_t [AXES-1:0]     p;
    coord_t [AXES-1:0]     q;
    logic [RS_W-1:0]       rad;
  } s1_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  bb_hit;
    diff_t [AXES-1:0]      d;
    logic [RS_W-1:0]       rad;
  } s2_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  bb_hit;
    sq_t [AXES-1:0]        sq;
    logic [RSQ_W-1:0]      rsq;
  } s3_t;

  // signed coordinate of one axis, bits above the field read as zero
  function automatic coord_t coord_get(input logic [FIELD_W-1:0] f, input int axis);
    logic [PAD_W-1:0] ext;
    ext = {{(PAD_W-FIELD_W){1'b0}}, f};
    return coord_t'(ext[axis*COORD_WIDTH +: COORD_WIDTH]);
  endfunction

endpackage
`default_nettype wire

@@ src/cnp_ifs.sv @@
// valid/ready channel interfaces for body pairs and collision results
`default_nettype none
interface cnp_in_if;
  import cnp_pkg::*;
  logic               valid;
  logic               ready;
  logic               a_is_sphere;
  logic               b_is_sphere;
  logic [FIELD_W-1:0] a_center;
  logic [FIELD_W-1:0] b_center;
  logic [FIELD_W-1:0] a_box_min;
  logic [FIELD_W-1:0] a_box_max;
  logic [FIELD_W-1:0] b_box_min;
  logic [FIELD_W-1:0] b_box_max;
  logic [RAD_W-1:0]   a_radius;
  logic [RAD_W-1:0]   b_radius;

  modport source (output valid, a_is_sphere, b_is_sphere, a_center, b_center,
                  a_box_min, a_box_max, b_box_min, b_box_max, a_radius, b_radius,
                  input ready);
  modport sink (input valid, a_is_sphere, b_is_sphere, a_center, b_center,
                a_box_min, a_box_max, b_box_min, b_box_max, a_radius, b_radius,
                output ready);
endinterface

interface cnp_out_if;
  logic valid;
  logic ready;
  logic collides;

  modport source (output valid, collides, input ready);
  modport sink (input valid, collides, output ready);
endinterface
`default_nettype wire

@@ src/cnp_select.sv @@
// stage 1: test selection, sphere center clamp and box overlap compares
`default_nettype none
module cnp_select (
  input  wire logic    clk,
  input  wire logic    rst_n,
  cnp_in_if.sink       in_ch,
  output cnp_pkg::s1_t s1_o,
  output logic         s1_valid_o,
  input  wire logic    s1_ready_i
);
  import cnp_pkg::*;

  logic valid_r;
  s1_t  data_r;
  s1_t  data_nxt;
  logic stage_rdy;

  assign stage_rdy   = !valid_r || s1_ready_i;
  assign in_ch.ready = stage_rdy;

  always_comb begin
    logic               sa;
    logic               sb;
    logic [FIELD_W-1:0] ctr;
    logic [FIELD_W-1:0] lo_f;
    logic [FIELD_W-1:0] hi_f;
    coord_t             p;
    coord_t             lo;
    coord_t             hi;
    coord_t             q;
    logic               ovl;
    sa   = in_ch.a_is_sphere;
    sb   = in_ch.b_is_sphere;
    ctr  = sa ? in_ch.a_center : in_ch.b_center;
    lo_f = sa ? in_ch.b_box_min : in_ch.a_box_min;
    hi_f = sa ? in_ch.b_box_max : in_ch.a_box_max;
    ovl  = 1'b1;
    data_nxt = '0;
    if (sa && sb) begin
      data_nxt.mode = MODE_SS;
      data_nxt.rad  = {1'b0, in_ch.a_radius} + {1'b0, in_ch.b_radius};
    end else if (sa || sb) begin
      data_nxt.mode = MODE_SB;
      data_nxt.rad  = {1'b0, (sa ? in_ch.a_radius : in_ch.b_radius)};
    end else begin
      data_nxt.mode = MODE_BB;
      data_nxt.rad  = '0;
    end
    for (int i = 0; i < AXES; i++) begin
      p  = coord_get(ctr, i);
      lo = coord_get(lo_f, i);
      hi = coord_get(hi_f, i);
      // clamp to max first, then raise to min
      q  = (p > hi) ? hi : p;
      q  = (q < lo) ? lo : q;
      if (sa && sb) begin
        data_nxt.p[i] = coord_get(in_ch.a_center, i);
        data_nxt.q[i] = coord_get(in_ch.b_center, i);
      end else begin
        data_nxt.p[i] = p;
        data_nxt.q[i] = q;
      end
      if (!(coord_get(in_ch.a_box_max, i) >= coord_get(in_ch.b_box_min, i) &&
            coord_get(in_ch.a_box_min, i) <= coord_get(in_ch.b_box_max, i))) begin
        ovl = 1'b0;
      end
    end
    data_nxt.bb_hit = ovl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stage_rdy) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

  assign s1_o       = data_r;
  assign s1_valid_o = valid_r;
endmodule
`default_nettype wire

@@ src/cnp_dist.sv @@
// stages 2 and 3: per-axis difference, then squares of differences and radius
`default_nettype none
module cnp_dist (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cnp_pkg::s1_t  s1_i,
  input  wire logic          s1_valid_i,
  output logic               s1_ready_o,
  output cnp_pkg::s3_t       s3_o,
  output logic               s3_valid_o,
  input  wire logic          s3_ready_i
);
  import cnp_pkg::*;

  logic v2_r;
  logic v3_r;
  s2_t  s2_r;
  s2_t  s2_nxt;
  s3_t  s3_r;
  s3_t  s3_nxt;
  logic rdy2;
  logic rdy3;

  assign rdy3       = !v3_r || s3_ready_i;
  assign rdy2       = !v2_r || rdy3;
  assign s1_ready_o = rdy2;

  always_comb begin
    s2_nxt.mode   = s1_i.mode;
    s2_nxt.bb_hit = s1_i.bb_hit;
    s2_nxt.rad    = s1_i.rad;
    for (int i = 0; i < AXES; i++) begin
      s2_nxt.d[i] = $signed({s1_i.p[i][COORD_WIDTH-1], s1_i.p[i]})
                  - $signed({s1_i.q[i][COORD_WIDTH-1], s1_i.q[i]});
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    s3_nxt.mode   = s2_r.mode;
    s3_nxt.bb_hit = s2_r.bb_hit;
    s3_nxt.rsq    = s2_r.rad * s2_r.rad;
    for (int i = 0; i < AXES; i++) begin
      prod = $signed(s2_r.d[i]) * $signed(s2_r.d[i]);
      // a square of a difference stays below 2^(2*COORD_WIDTH)
      s3_nxt.sq[i] = prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= s1_valid_i;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid_i) s2_r <= s2_nxt;
    if (rdy3 && v2_r)       s3_r <= s3_nxt;
  end

  assign s3_o       = s3_r;
  assign s3_valid_o = v3_r;
endmodule
`default_nettype wire

@@ src/cnp_decide.sv @@
// stage 4: distance sum, final compare and output register
`default_nettype none
module cnp_decide (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cnp_pkg::s3_t  s3_i,
  input  wire logic          s3_valid_i,
  output logic               s3_ready_o,
  cnp_out_if.source          out_ch
);
  import cnp_pkg::*;

  logic valid_r;
  logic hit_r;
  logic hit_nxt;
  logic stage_rdy;

  assign stage_rdy  = !valid_r || out_ch.ready;
  assign s3_ready_o = stage_rdy;

  always_comb begin
    logic [CMP_W-1:0] d2;
    logic [CMP_W-1:0] r2;
    d2 = CMP_W'({2'b00, s3_i.sq[0]}) + CMP_W'({2'b00, s3_i.sq[1]})
       + CMP_W'({2'b00, s3_i.sq[2]});
    r2 = CMP_W'(s3_i.rsq);
    unique case (s3_i.mode)
      MODE_SS: hit_nxt = (d2 <= r2);
      MODE_SB: hit_nxt = (d2 < r2);
      MODE_BB: hit_nxt = s3_i.bb_hit;
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stage_rdy) begin
      valid_r <= s3_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy && s3_valid_i) hit_r <= hit_nxt;
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.collides = hit_r;
endmodule
`default_nettype wire

@@ src/collision_narrowphase_test_unit.sv @@
// top level of the sphere/box narrow-phase collision test pipeline
// path: a word accepted into stage 1 moves on through the stage 2, 3 and 4 registers to out_ch
// throughput: one word per cycle while out_ch is not stalled, set by the four register stages each taking one word
// stalls: every stage keeps its word until the next one frees, bubbles close up
// reset: rst_n synchronous active low, clears the stage valid bits only
`default_nettype none
module collision_narrowphase_test_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  cnp_in_if.sink    in_ch,
  cnp_out_if.source out_ch
);
  import cnp_pkg::*;

  // stage 1 -> stages 2/3
  s1_t  s1;
  logic s1_valid;
  logic s1_ready;
  // stage 3 -> stage 4
  s3_t  s3;
  logic s3_valid;
  logic s3_ready;

  // picks the test, clamps the sphere center, compares box extents
  cnp_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .s1_o       (s1),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready)
  );

  // differences, then squares of the differences and of the radius term
  cnp_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_i       (s1),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s3_o       (s3),
    .s3_valid_o (s3_valid),
    .s3_ready_i (s3_ready)
  );

  // sum of squares against the radius square, or the box overlap bit
  cnp_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .s3_i       (s3),
    .s3_valid_i (s3_valid),
    .s3_ready_o (s3_ready),
    .out_ch     (out_ch)
  );
endmodule
`default_nettype wire

@@ src/cnp_checker.sv @@
// port-level checker of the collision test unit and its bind
`default_nettype none
`include "collision_narrowphase_test_unit_macros.svh"
module cnp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_collides
);
  `CNP_ASSERT_RUN(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
  `CNP_ASSERT_RUN(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_collides), "stalled result word changed")
  `CNP_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result valid after reset")
  `CNP_ASSERT_ALWAYS(a_flow, clk, out_ready |-> in_ready, "input stalled with output free")
endmodule

bind collision_narrowphase_test_unit cnp_checker u_cnp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_collides (out_ch.collides)
);
`default_nettype wire

@@ verif/collision_narrowphase_test_unit_checker.sv @@
`timescale 1ns / 100ps
// checker for the narrow-phase collision test unit: predicts each pair's verdict and compares
module collision_narrowphase_test_unit_checker (
  input  logic clk,
  input  logic rst_n,
  cnp_in_if    in_ch,
  cnp_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   pairs_ss,
  output int   pairs_sb,
  output int   pairs_bb,
  output int   hits_seen
);
  import cnp_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    bit    collides;
    mode_t mode;
    int    seq;
  } verdict_t;

  verdict_t verdict_q[$];
  int       words_in = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    pairs_ss   = 0;
    pairs_sb   = 0;
    pairs_bb   = 0;
    hits_seen  = 0;
  end

  // signed coordinate of one axis, bits past the packed field read as zero
  function automatic longint axis_val(input logic [FIELD_W-1:0] f, input int ax);
    logic [63:0] w;
    int          sh;
    w  = 64'(f);
    sh = ax * COORD_WIDTH;
    w  = (sh < 64) ? ((w >> sh) & ((64'd1 << COORD_WIDTH) - 64'd1)) : 64'd0;
    if (w[COORD_WIDTH-1]) return longint'(w) - (longint'(1) << COORD_WIDTH);
    return longint'(w);
  endfunction

  function automatic bit spheres_touch(input logic [FIELD_W-1:0] ca, cb,
                                       input logic [RAD_W-1:0] ra, rb);
    longint d, d2, rs;
    d2 = 0;
    for (int ax = 0; ax < AXES; ax++) begin
      d  = axis_val(ca, ax) - axis_val(cb, ax);
      d2 += d * d;
    end
    rs = longint'(ra) + longint'(rb);
    return d2 <= rs * rs;
  endfunction

  // clamp to max first, then to min, so an inverted axis lands on min
  function automatic bit sphere_meets_box(input logic [FIELD_W-1:0] c,
                                          input logic [RAD_W-1:0] r,
                                          input logic [FIELD_W-1:0] lo_f, hi_f);
    longint p, q, d, d2, rl;
    d2 = 0;
    for (int ax = 0; ax < AXES; ax++) begin
      p = axis_val(c, ax);
      q = p;
      if (q > axis_val(hi_f, ax)) q = axis_val(hi_f, ax);
      if (q < axis_val(lo_f, ax)) q = axis_val(lo_f, ax);
      d  = p - q;
      d2 += d * d;
    end
    rl = longint'(r);
    return d2 < rl * rl;
  endfunction

  function automatic bit boxes_overlap(input logic [FIELD_W-1:0] amn, amx, bmn, bmx);
    for (int ax = 0; ax < AXES; ax++) begin
      if (!(axis_val(amx, ax) >= axis_val(bmn, ax) &&
            axis_val(amn, ax) <= axis_val(bmx, ax)))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t exp_w;
    verdict_t new_w;
    if (rst_n) begin
      // results first so a same-edge pair never answers itself
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: result word with no pair outstanding, collides=%0b",
                     $realtime, out_ch.collides);
          fail_count++;
        end else begin
          exp_w = verdict_q.pop_front();
          if (out_ch.collides !== exp_w.collides) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: pair %0d (%s) expected collides=%0b, got %0b",
                       $realtime, exp_w.seq, exp_w.mode.name(), exp_w.collides,
                       out_ch.collides);
            fail_count++;
          end
          if (exp_w.collides) hits_seen++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        new_w.seq = words_in;
        words_in++;
        if (in_ch.a_is_sphere && in_ch.b_is_sphere) begin
          new_w.mode     = MODE_SS;
          new_w.collides = spheres_touch(in_ch.a_center, in_ch.b_center,
                                         in_ch.a_radius, in_ch.b_radius);
          pairs_ss++;
        end else if (in_ch.a_is_sphere) begin
          new_w.mode     = MODE_SB;
          new_w.collides = sphere_meets_box(in_ch.a_center, in_ch.a_radius,
                                            in_ch.b_box_min, in_ch.b_box_max);
          pairs_sb++;
        end else if (in_ch.b_is_sphere) begin
          new_w.mode     = MODE_SB;
          new_w.collides = sphere_meets_box(in_ch.b_center, in_ch.b_radius,
                                            in_ch.a_box_min, in_ch.a_box_max);
          pairs_sb++;
        end else begin
          new_w.mode     = MODE_BB;
          new_w.collides = boxes_overlap(in_ch.a_box_min, in_ch.a_box_max,
                                         in_ch.b_box_min, in_ch.b_box_max);
          pairs_bb++;
        end
        verdict_q.push_back(new_w);
      end
      pending = verdict_q.size();
    end
  end

endmodule

@@ verif/collision_narrowphase_test_unit_test.sv @@
`timescale 1ns / 100ps
// top of the narrow-phase collision test: clock, reset, pair stimulus, result pacing, verdict
module collision_narrowphase_test_unit_test;
  import cnp_pkg::*;

  // run shape: directed pairs, paced phases, one surge, then a quiet tail
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int SURGE_ITEMS = 40;
  localparam int TAIL_ITEMS  = 335;
  localparam int LONG_HOLD   = 60;
  localparam int DRAIN_WAIT  = 16;
  localparam int TIMEOUT_NS  = 6_000_000;
  localparam int Q_ONE       = 256;

  localparam logic [FIELD_W-1:0] F_ONES = '1;
  localparam logic [FIELD_W-1:0] F_ZERO = '0;

  // how a random pair's coordinates are drawn
  typedef enum int {
    DRAW_NOISE,
    DRAW_GRID,
    DRAW_NEAR
  } draw_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  cnp_in_if  in_ch();
  cnp_out_if out_ch();

  // pacing knobs of the sender and the receiver
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;

  int chk_fails;
  int chk_pending;
  int n_ss, n_sb, n_bb, n_hits;

  collision_narrowphase_test_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  collision_narrowphase_test_unit_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (chk_fails),
    .pending    (chk_pending),
    .pairs_ss   (n_ss),
    .pairs_sb   (n_sb),
    .pairs_bb   (n_bb),
    .hits_seen  (n_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pack three Q8.8 coordinates as z:y:x
  function automatic logic [FIELD_W-1:0] pack_xyz(input int x, y, z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  function automatic coord_t near_coord(input draw_kind_t kind, input coord_t base);
    case (kind)
      DRAW_NOISE: return coord_t'($urandom);
      // whole units only, so exact touching happens often
      DRAW_GRID:  return coord_t'((int'($urandom_range(0, 8)) - 4) * Q_ONE);
      default:    return coord_t'(int'(base) + int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  // upper box corner from the lower one, now and then inverted
  function automatic coord_t box_far(input draw_kind_t kind, input coord_t lo);
    case (kind)
      DRAW_NOISE: return coord_t'($urandom);
      DRAW_GRID: begin
        if ($urandom_range(0, 9) == 0) return coord_t'(int'(lo) - Q_ONE);
        return coord_t'(int'(lo) + int'($urandom_range(0, 3)) * Q_ONE);
      end
      default: begin
        if ($urandom_range(0, 19) == 0)
          return coord_t'(int'(lo) - int'($urandom_range(1, 64)));
        return coord_t'(int'(lo) + int'($urandom_range(0, 768)));
      end
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius(input draw_kind_t kind);
    case (kind)
      DRAW_NOISE: return RAD_W'($urandom_range(0, 65535));
      DRAW_GRID:  return RAD_W'($urandom_range(0, 3) * Q_ONE);
      default:    return RAD_W'($urandom_range(0, 600));
    endcase
  endfunction

  // put one pair word on the input channel and hold it until taken
  task automatic offer_pair(input bit sa, sb,
                            input logic [FIELD_W-1:0] ac, bc, amn, amx, bmn, bmx,
                            input logic [RAD_W-1:0] ar, br);
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.a_is_sphere <= sa;
    in_ch.b_is_sphere <= sb;
    in_ch.a_center    <= ac;
    in_ch.b_center    <= bc;
    in_ch.a_box_min   <= amn;
    in_ch.a_box_max   <= amx;
    in_ch.b_box_min   <= bmn;
    in_ch.b_box_max   <= bmx;
    in_ch.a_radius    <= ar;
    in_ch.b_radius    <= br;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // sender stops until every pair in flight has been answered
  task automatic wait_all_answered();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
  endtask

  task automatic random_pair();
    draw_kind_t          kind;
    int                  roll;
    coord_t              base;
    logic [FIELD_W-1:0]  ac, bc, amn, amx, bmn, bmx;
    roll = $urandom_range(0, 99);
    kind = (roll < 15) ? DRAW_NOISE : (roll < 50) ? DRAW_GRID : DRAW_NEAR;
    // in near draws both bodies gather around one point per axis so tests go either way
    for (int ax = 0; ax < AXES; ax++) begin
      base = coord_t'($urandom);
      ac[ax*COORD_WIDTH +: COORD_WIDTH]  = near_coord(kind, base);
      bc[ax*COORD_WIDTH +: COORD_WIDTH]  = near_coord(kind, base);
      amn[ax*COORD_WIDTH +: COORD_WIDTH] = near_coord(kind, base);
      amx[ax*COORD_WIDTH +: COORD_WIDTH] = box_far(kind, amn[ax*COORD_WIDTH +: COORD_WIDTH]);
      bmn[ax*COORD_WIDTH +: COORD_WIDTH] = near_coord(kind, base);
      bmx[ax*COORD_WIDTH +: COORD_WIDTH] = box_far(kind, bmn[ax*COORD_WIDTH +: COORD_WIDTH]);
    end
    offer_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               ac, bc, amn, amx, bmn, bmx, pick_radius(kind), pick_radius(kind));
  endtask

  // random gap before a word, as the current phase allows
  task automatic paced_random_pair();
    if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct)
      idle_input($urandom_range(1, 12));
    random_pair();
  endtask

  task automatic directed_pairs();
    // two spheres: identical centers with zero radii touch
    offer_pair(1'b1, 1'b1, pack_xyz(5, -7, 9), pack_xyz(5, -7, 9),
               F_ONES, F_ONES, F_ONES, F_ONES, '0, '0);
    // zero radii one lsb apart miss
    offer_pair(1'b1, 1'b1, pack_xyz(0, 0, 0), pack_xyz(1, 0, 0),
               F_ZERO, F_ZERO, F_ZERO, F_ZERO, '0, '0);
    // exactly tangent spheres count as touching, one lsb further they do not
    offer_pair(1'b1, 1'b1, pack_xyz(0, 0, 0), pack_xyz(3 * Q_ONE, 0, 0),
               F_ZERO, F_ZERO, F_ZERO, F_ZERO, RAD_W'(Q_ONE), RAD_W'(2 * Q_ONE));
    offer_pair(1'b1, 1'b1, pack_xyz(0, 0, 0), pack_xyz(3 * Q_ONE + 1, 0, 0),
               F_ZERO, F_ZERO, F_ZERO, F_ZERO, RAD_W'(Q_ONE), RAD_W'(2 * Q_ONE));
    // opposite corners of the coordinate range, largest and mid radii
    offer_pair(1'b1, 1'b1, pack_xyz(-32768, -32768, -32768), pack_xyz(32767, 32767, 32767),
               F_ONES, F_ONES, F_ONES, F_ONES, 16'hFFFF, 16'hFFFF);
    offer_pair(1'b1, 1'b1, pack_xyz(-32768, -32768, -32768), pack_xyz(32767, 32767, 32767),
               F_ONES, F_ONES, F_ONES, F_ONES, 16'h7FFF, 16'h7FFF);
    // sphere in a with box in b: inside, on the face (strict miss), just inside
    offer_pair(1'b1, 1'b0, pack_xyz(0, 0, 0), F_ONES, F_ONES, F_ONES,
               pack_xyz(-256, -256, -256), pack_xyz(256, 256, 256), 16'd1, 16'hFFFF);
    offer_pair(1'b1, 1'b0, pack_xyz(512, 0, 0), F_ZERO, F_ZERO, F_ZERO,
               pack_xyz(-256, -256, -256), pack_xyz(256, 256, 256), 16'd256, 16'd0);
    offer_pair(1'b1, 1'b0, pack_xyz(511, 0, 0), F_ZERO, F_ZERO, F_ZERO,
               pack_xyz(-256, -256, -256), pack_xyz(256, 256, 256), 16'd256, 16'd0);
    // zero radius inside a box never collides
    offer_pair(1'b1, 1'b0, pack_xyz(0, 0, 0), F_ZERO, F_ZERO, F_ZERO,
               pack_xyz(-256, -256, -256), pack_xyz(256, 256, 256), 16'd0, 16'd0);
    // sphere in b with box in a: face side hit, corner side near miss
    offer_pair(1'b0, 1'b1, F_ONES, pack_xyz(0, 0, 300), pack_xyz(-50, -50, -50),
               pack_xyz(50, 50, 250), F_ONES, F_ONES, 16'hFFFF, 16'd100);
    offer_pair(1'b0, 1'b1, F_ZERO, pack_xyz(300, 300, 300), pack_xyz(-250, -250, -250),
               pack_xyz(250, 250, 250), F_ZERO, F_ZERO, 16'd0, 16'd86);
    // inverted corner on x clamps to min: miss, then barely a hit
    offer_pair(1'b1, 1'b0, pack_xyz(0, 5, 5), F_ZERO, F_ZERO, F_ZERO,
               pack_xyz(100, 0, 0), pack_xyz(-100, 10, 10), 16'd50, 16'd0);
    offer_pair(1'b1, 1'b0, pack_xyz(0, 5, 5), F_ZERO, F_ZERO, F_ZERO,
               pack_xyz(100, 0, 0), pack_xyz(-100, 10, 10), 16'd101, 16'd0);
    // two boxes: overlap, touching faces, apart by one lsb on z
    offer_pair(1'b0, 1'b0, F_ONES, F_ONES, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256),
               pack_xyz(128, 128, 128), pack_xyz(512, 512, 512), 16'hFFFF, 16'hFFFF);
    offer_pair(1'b0, 1'b0, F_ZERO, F_ZERO, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256),
               pack_xyz(256, 0, 0), pack_xyz(512, 256, 256), 16'd0, 16'd0);
    offer_pair(1'b0, 1'b0, F_ZERO, F_ZERO, pack_xyz(0, 0, 0), pack_xyz(256, 256, 256),
               pack_xyz(0, 0, 257), pack_xyz(256, 256, 512), 16'd0, 16'd0);
    // inverted box corners are compared as given
    offer_pair(1'b0, 1'b0, F_ZERO, F_ZERO, pack_xyz(10, 0, 0), pack_xyz(-10, 5, 5),
               pack_xyz(-20, 0, 0), pack_xyz(20, 5, 5), 16'd0, 16'd0);
    // full-range boxes: shared corner hits, opposite corners miss
    offer_pair(1'b0, 1'b0, F_ONES, F_ONES, pack_xyz(-32768, -32768, -32768),
               pack_xyz(32767, 32767, 32767), pack_xyz(32767, 32767, 32767),
               pack_xyz(32767, 32767, 32767), 16'hFFFF, 16'hFFFF);
    offer_pair(1'b0, 1'b0, F_ONES, F_ONES, pack_xyz(-32768, -32768, -32768),
               pack_xyz(-32768, -32768, -32768), pack_xyz(32767, 32767, 32767),
               pack_xyz(32767, 32767, 32767), 16'hFFFF, 16'hFFFF);
    // every field zero in each shape mix, then every field ones for two spheres and two boxes
    offer_pair(1'b1, 1'b1, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, '0, '0);
    offer_pair(1'b1, 1'b0, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, '0, '0);
    offer_pair(1'b0, 1'b1, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, '0, '0);
    offer_pair(1'b0, 1'b0, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, '0, '0);
    offer_pair(1'b1, 1'b1, F_ONES, F_ONES, F_ONES, F_ONES, F_ONES, F_ONES, '1, '1);
    offer_pair(1'b0, 1'b0, F_ONES, F_ONES, F_ONES, F_ONES, F_ONES, F_ONES, '1, '1);
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int burst;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    in_ch.valid       = 1'b0;
    in_ch.a_is_sphere = 1'b0;
    in_ch.b_is_sphere = 1'b0;
    in_ch.a_center    = '0;
    in_ch.b_center    = '0;
    in_ch.a_box_min   = '0;
    in_ch.a_box_max   = '0;
    in_ch.b_box_min   = '0;
    in_ch.b_box_max   = '0;
    in_ch.a_radius    = '0;
    in_ch.b_radius    = '0;
    rst_n             = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_pairs();

    // paced phases: none, even, sender-heavy, receiver-heavy
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 10; sink_stall_pct = 10; end
        2: begin src_gap_pct = 30; sink_stall_pct = 5;  end
        default: begin src_gap_pct = 5; sink_stall_pct = 35; end
      endcase
      if (ph == 3) begin
        // receiver holds off while words keep coming, so the pipe backs up
        hold_req = 1'b1;
        repeat (SURGE_ITEMS) random_pair();
      end
      if (ph == 6) wait_all_answered();
      repeat (PHASE_ITEMS) paced_random_pair();
    end

    // quiet tail, both sides at full rate
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    repeat (TAIL_ITEMS) random_pair();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d pairs: %0d sphere-sphere, %0d sphere-box, %0d box-box",
             n_ss + n_sb + n_bb, n_ss, n_sb, n_bb);
    $display("%0d collisions among the results, %0d failures, %0d words left unanswered",
             n_hits, chk_fails, chk_pending);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d words still unanswered", chk_pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/cnp_pkg.sv
src/cnp_ifs.sv
src/cnp_select.sv
src/cnp_dist.sv
src/cnp_decide.sv
src/collision_narrowphase_test_unit.sv
src/cnp_checker.sv
verif/collision_narrowphase_test_unit_checker.sv
verif/collision_narrowphase_test_unit_test.sv
